[hw/rtl/assert_macros.svh]
// Assertion helpers used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/tppcq_pkg.sv]
package tppcq_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;

    localparam int NODE_FIELD_W = 11;
    localparam int ANSWER_W     = 30;
    localparam int LEN_W        = 10;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [ANSWER_W:0] PMOD = 31'd1000000007;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_W-1:0] OP_EDGE   = 5'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 5'd2;
    localparam logic [OP_W-1:0] OP_CLR    = 5'd3;
    localparam logic [OP_W-1:0] OP_ROOT   = 5'd4;
    localparam logic [OP_W-1:0] OP_POP    = 5'd5;
    localparam logic [OP_W-1:0] OP_POPW   = 5'd6;
    localparam logic [OP_W-1:0] OP_ULVL   = 5'd7;
    localparam logic [OP_W-1:0] OP_EREAD  = 5'd8;
    localparam logic [OP_W-1:0] OP_ECHK   = 5'd9;
    localparam logic [OP_W-1:0] OP_EVIS   = 5'd10;
    localparam logic [OP_W-1:0] OP_FA     = 5'd11;
    localparam logic [OP_W-1:0] OP_FB     = 5'd12;
    localparam logic [OP_W-1:0] OP_FC     = 5'd13;
    localparam logic [OP_W-1:0] OP_BUILT  = 5'd14;
    localparam logic [OP_W-1:0] OP_QCHK   = 5'd15;
    localparam logic [OP_W-1:0] OP_QLVL   = 5'd16;
    localparam logic [OP_W-1:0] OP_LIFT   = 5'd17;
    localparam logic [OP_W-1:0] OP_LIFTW  = 5'd18;
    localparam logic [OP_W-1:0] OP_CMP    = 5'd19;
    localparam logic [OP_W-1:0] OP_CLB    = 5'd20;
    localparam logic [OP_W-1:0] OP_CLBW   = 5'd21;
    localparam logic [OP_W-1:0] OP_PAR    = 5'd22;
    localparam logic [OP_W-1:0] OP_PARW   = 5'd23;
    localparam logic [OP_W-1:0] OP_LCALVL = 5'd24;
    localparam logic [OP_W-1:0] OP_DIST   = 5'd25;
    localparam logic [OP_W-1:0] OP_POW    = 5'd26;
    localparam logic [OP_W-1:0] OP_POWW   = 5'd27;
    localparam logic [OP_W-1:0] OP_OUT    = 5'd28;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic built;
        logic bad;
        logic clr_last;
        logic stack_empty;
        logic scan_done;
        logic fill_last;
        logic lift_last;
        logic climb_last;
        logic nodes_eq;
    } stat_t;

endpackage

[hw/rtl/tree_path_parity_count_query_core.sv]
// Edge transfer: taken with no result. Query on a built tree: node check, level read, lift,
// climb through the ancestor memory, distance and power lookup. The first query after edges
// adds the build before it: clear of nodes 0..n, an edge scan for each reached node and the
// ancestor table fill for levels 1..LIFT_LEVELS-1 (n = edges + 1).
// One item at a time. Reset (rst_n low, async) empties the edge list, drops the built tree
// and the pending result; the tables are rewritten by each build and need no clearing.
`include "assert_macros.svh"

module tree_path_parity_count_query_core #(
    parameter int MAX_NODES   = tppcq_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = tppcq_pkg::LIFT_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [10:0] node_a, [21:11] node_b, [23:22] zero
    input  logic [tppcq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] func: 0 loads an edge, 1 asks a path query
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [29:0] answer, [39:30] path_length
    output logic [tppcq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] bad_node
    output logic                               m_axis_tuser
);

    tppcq_pkg::cmd_t  cmd;
    tppcq_pkg::stat_t stat;

    logic [tppcq_pkg::ANSWER_W-1:0] answer;
    logic [tppcq_pkg::LEN_W-1:0]    path_length;

    // Sequencer: walks the build (clear, depth-first scan, table fill) and the query (level
    // read, lift, climb, distance, power lookup) one step a cycle, but waits on a busy output.
    tppcq_ctrl #(
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: edge list, stack, visited marks, levels, ancestor table and
    // power table, plus the registers the sequencer steps through. The result
    // register doubles as the output stage, so a new edge transfer can be taken
    // while a finished answer waits downstream.
    tppcq_dp #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (s_axis_tdata),
        .stat        (stat),
        .answer      (answer),
        .path_length (path_length),
        .bad_node    (m_axis_tuser)
    );

    assign m_axis_tdata = {path_length, answer};

    // A query holds the input side off while it runs.
    `ASSERT_NXT(a_query_busy, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
    // An edge transfer leaves the input side ready in the following cycle.
    `ASSERT_NXT(a_edge_quick, clk, rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready)
    // A rejected node gives an all-zero answer and length.
    `ASSERT_IMP(a_bad_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    // The output stage is reloaded only when it is free or draining.
    `ASSERT_IMP(a_out_load, clk, rst_n, cmd.op == tppcq_pkg::OP_OUT, !m_axis_tvalid || m_axis_tready)

endmodule

[hw/rtl/tppcq_ctrl.sv]
module tppcq_ctrl #(
    parameter int LIFT_LEVELS = tppcq_pkg::LIFT_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tppcq_pkg::stat_t  stat,
    output tppcq_pkg::cmd_t   cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CLR    = 5'd1;
    localparam logic [4:0] ST_ROOT   = 5'd2;
    localparam logic [4:0] ST_POP    = 5'd3;
    localparam logic [4:0] ST_POPW   = 5'd4;
    localparam logic [4:0] ST_ULVL   = 5'd5;
    localparam logic [4:0] ST_ESCAN  = 5'd6;
    localparam logic [4:0] ST_ECHK   = 5'd7;
    localparam logic [4:0] ST_EVIS   = 5'd8;
    localparam logic [4:0] ST_FILLA  = 5'd9;
    localparam logic [4:0] ST_FILLB  = 5'd10;
    localparam logic [4:0] ST_FILLC  = 5'd11;
    localparam logic [4:0] ST_BUILT  = 5'd12;
    localparam logic [4:0] ST_QCHK   = 5'd13;
    localparam logic [4:0] ST_QLVL   = 5'd14;
    localparam logic [4:0] ST_LIFT   = 5'd15;
    localparam logic [4:0] ST_LIFTW  = 5'd16;
    localparam logic [4:0] ST_CMP    = 5'd17;
    localparam logic [4:0] ST_CLB    = 5'd18;
    localparam logic [4:0] ST_CLBW   = 5'd19;
    localparam logic [4:0] ST_PAR    = 5'd20;
    localparam logic [4:0] ST_PARW   = 5'd21;
    localparam logic [4:0] ST_LCALVL = 5'd22;
    localparam logic [4:0] ST_DIST   = 5'd23;
    localparam logic [4:0] ST_POW    = 5'd24;
    localparam logic [4:0] ST_POWW   = 5'd25;
    localparam logic [4:0] ST_OUT    = 5'd26;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = tppcq_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func)
                    begin
                        cmd.op     = tppcq_pkg::OP_QUERY;
                        state_next = stat.built ? ST_QCHK : ST_CLR;
                    end
                    else
                    begin
                        cmd.op = tppcq_pkg::OP_EDGE;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.op = tppcq_pkg::OP_CLR;
                if (stat.clr_last)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.op     = tppcq_pkg::OP_ROOT;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (stat.stack_empty)
                    state_next = (LIFT_LEVELS > 1) ? ST_FILLA : ST_BUILT;
                else
                begin
                    cmd.op     = tppcq_pkg::OP_POP;
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                cmd.op     = tppcq_pkg::OP_POPW;
                state_next = ST_ULVL;
            end
            ST_ULVL:
            begin
                cmd.op     = tppcq_pkg::OP_ULVL;
                state_next = ST_ESCAN;
            end
            ST_ESCAN:
            begin
                if (stat.scan_done)
                    state_next = ST_POP;
                else
                begin
                    cmd.op     = tppcq_pkg::OP_EREAD;
                    state_next = ST_ECHK;
                end
            end
            ST_ECHK:
            begin
                cmd.op     = tppcq_pkg::OP_ECHK;
                state_next = ST_EVIS;
            end
            ST_EVIS:
            begin
                cmd.op     = tppcq_pkg::OP_EVIS;
                state_next = ST_ESCAN;
            end
            ST_FILLA:
            begin
                cmd.op     = tppcq_pkg::OP_FA;
                state_next = ST_FILLB;
            end
            ST_FILLB:
            begin
                cmd.op     = tppcq_pkg::OP_FB;
                state_next = ST_FILLC;
            end
            ST_FILLC:
            begin
                cmd.op     = tppcq_pkg::OP_FC;
                state_next = stat.fill_last ? ST_BUILT : ST_FILLA;
            end
            ST_BUILT:
            begin
                cmd.op     = tppcq_pkg::OP_BUILT;
                state_next = ST_QCHK;
            end
            ST_QCHK:
            begin
                cmd.op     = tppcq_pkg::OP_QCHK;
                state_next = stat.bad ? ST_OUT : ST_QLVL;
            end
            ST_QLVL:
            begin
                cmd.op     = tppcq_pkg::OP_QLVL;
                state_next = ST_LIFT;
            end
            ST_LIFT:
            begin
                cmd.op     = tppcq_pkg::OP_LIFT;
                state_next = ST_LIFTW;
            end
            ST_LIFTW:
            begin
                cmd.op     = tppcq_pkg::OP_LIFTW;
                state_next = stat.lift_last ? ST_CMP : ST_LIFT;
            end
            ST_CMP:
            begin
                cmd.op     = tppcq_pkg::OP_CMP;
                state_next = stat.nodes_eq ? ST_LCALVL : ST_CLB;
            end
            ST_CLB:
            begin
                cmd.op     = tppcq_pkg::OP_CLB;
                state_next = ST_CLBW;
            end
            ST_CLBW:
            begin
                cmd.op     = tppcq_pkg::OP_CLBW;
                state_next = stat.climb_last ? ST_PAR : ST_CLB;
            end
            ST_PAR:
            begin
                cmd.op     = tppcq_pkg::OP_PAR;
                state_next = ST_PARW;
            end
            ST_PARW:
            begin
                cmd.op     = tppcq_pkg::OP_PARW;
                state_next = ST_LCALVL;
            end
            ST_LCALVL:
            begin
                cmd.op     = tppcq_pkg::OP_LCALVL;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op     = tppcq_pkg::OP_DIST;
                state_next = ST_POW;
            end
            ST_POW:
            begin
                cmd.op     = tppcq_pkg::OP_POW;
                state_next = ST_POWW;
            end
            ST_POWW:
            begin
                cmd.op     = tppcq_pkg::OP_POWW;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = tppcq_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/tppcq_dp.sv]
module tppcq_dp #(
    parameter int MAX_NODES   = tppcq_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = tppcq_pkg::LIFT_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tppcq_pkg::cmd_t                   cmd,
    input  logic [tppcq_pkg::IN_TDATA_W-1:0]  in_data,
    output tppcq_pkg::stat_t                  stat,
    output logic [tppcq_pkg::ANSWER_W-1:0]    answer,
    output logic [tppcq_pkg::LEN_W-1:0]       path_length,
    output logic                              bad_node
);

    localparam int FW   = tppcq_pkg::NODE_FIELD_W;
    localparam int AWD  = tppcq_pkg::ANSWER_W;
    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int IW   = $clog2(MAX_NODES);
    localparam int KW   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int AW   = KW + NW;
    localparam int CMPW = (NW > FW) ? NW : FW;

    // memories
    logic [2*FW-1:0] edge_mem [MAX_NODES-1];
    logic [NW-1:0]   stk_mem  [MAX_NODES];
    logic            vis_mem  [MAX_NODES+1];
    logic [IW-1:0]   lvl_mem  [MAX_NODES+1];
    logic [NW-1:0]   anc_mem  [2**AW];
    logic [AWD-1:0]  pow_mem  [MAX_NODES];

    logic [2*FW-1:0] edge_q;
    logic [NW-1:0]   stk_q;
    logic            vis_q;
    logic [IW-1:0]   lvl_qa, lvl_qb;
    logic [NW-1:0]   anc_qa, anc_qb;
    logic [AWD-1:0]  pow_q;

    // control state
    logic [IW-1:0] ec_reg;
    logic          built_reg;

    // working registers
    logic [FW-1:0]  qa_reg, qb_reg;
    logic [NW-1:0]  clr_reg, sp_reg, u_reg, v_reg, tgt_reg;
    logic [AWD-1:0] pw_reg;
    logic [IW-1:0]  lvl_u_reg, ei_reg, du_reg, dv_reg, diff_reg;
    logic           hit_reg;
    logic [KW-1:0]  k_reg;
    logic [IW:0]    d_reg;
    logic [AWD-1:0] ans_reg;
    logic           bad_reg;
    logic [AWD-1:0] ans_out_reg;
    logic [tppcq_pkg::LEN_W-1:0] len_out_reg;
    logic           bad_out_reg;

    logic [FW-1:0]   in_a, in_b, ea, eb;
    logic [NW-1:0]   n_node;
    logic [CMPW-1:0] n_x, qa_x, qb_x, ea_x, eb_x, u_x;
    logic            q_bad, e_ok, echk_hit, do_visit, push_ok;
    logic [NW-1:0]   echk_tgt;
    logic [AWD:0]    pw_dbl;
    logic [AWD-1:0]  pw_next;
    logic [KW-1:0]   km1;
    logic [IW-1:0]   diff_sh;
    logic [IW:0]     lv_sum, lv_two, path_d;
    logic [IW-1:0]   pow_ra;
    logic            edge_we;
    logic [IW-1:0]   edge_wa;

    assign in_a   = in_data[FW-1:0];
    assign in_b   = in_data[2*FW-1:FW];
    assign n_node = NW'(ec_reg) + NW'(1);
    assign n_x    = CMPW'(n_node);
    assign qa_x   = CMPW'(qa_reg);
    assign qb_x   = CMPW'(qb_reg);
    assign q_bad  = (qa_reg == '0) || (qb_reg == '0) || (qa_x > n_x) || (qb_x > n_x);

    // edge decode for the scan
    assign ea       = edge_q[FW-1:0];
    assign eb       = edge_q[2*FW-1:FW];
    assign ea_x     = CMPW'(ea);
    assign eb_x     = CMPW'(eb);
    assign u_x      = CMPW'(u_reg);
    assign e_ok     = (ea != '0) && (eb != '0) && (ea_x <= n_x) && (eb_x <= n_x);
    assign echk_hit = e_ok && ((ea_x == u_x) || (eb_x == u_x));
    assign echk_tgt = (ea_x == u_x) ? NW'(eb) : NW'(ea);
    assign do_visit = hit_reg && !vis_q;
    assign push_ok  = (sp_reg < MAX_NODES);

    assign pw_dbl  = {pw_reg, 1'b0};
    assign pw_next = (pw_dbl >= tppcq_pkg::PMOD) ? AWD'(pw_dbl - tppcq_pkg::PMOD)
                                                 : AWD'(pw_dbl);

    assign km1     = k_reg - KW'(1);
    assign diff_sh = diff_reg >> k_reg;
    assign lv_sum  = (IW+1)'(du_reg) + (IW+1)'(dv_reg);
    assign lv_two  = {lvl_qa, 1'b0};
    assign path_d  = (lv_sum >= lv_two) ? (lv_sum - lv_two) : '0;
    assign pow_ra  = IW'(d_reg - (IW+1)'(1));

    assign edge_we = (cmd.op == tppcq_pkg::OP_EDGE) && (built_reg || (ec_reg < (MAX_NODES - 1)));
    assign edge_wa = built_reg ? '0 : ec_reg;

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= in_data[2*FW-1:0];
        edge_q <= edge_mem[ei_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tppcq_pkg::OP_ROOT)
            stk_mem[0] <= NW'(1);
        else if ((cmd.op == tppcq_pkg::OP_EVIS) && do_visit && push_ok)
            stk_mem[sp_reg[IW-1:0]] <= tgt_reg;
        stk_q <= stk_mem[IW'(sp_reg - NW'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tppcq_pkg::OP_CLR)
            vis_mem[clr_reg] <= 1'b0;
        else if (cmd.op == tppcq_pkg::OP_ROOT)
            vis_mem[NW'(1)] <= 1'b1;
        else if ((cmd.op == tppcq_pkg::OP_EVIS) && do_visit)
            vis_mem[tgt_reg] <= 1'b1;
        vis_q <= vis_mem[echk_tgt];
    end

    logic [NW-1:0] lvl_ra;

    always_comb
    begin
        priority if (cmd.op == tppcq_pkg::OP_QCHK)
            lvl_ra = NW'(qa_reg);
        else if (cmd.op == tppcq_pkg::OP_POPW)
            lvl_ra = stk_q;
        else
            lvl_ra = v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tppcq_pkg::OP_CLR)
            lvl_mem[clr_reg] <= '0;
        else if ((cmd.op == tppcq_pkg::OP_EVIS) && do_visit)
            lvl_mem[tgt_reg] <= lvl_u_reg + IW'(1);
        lvl_qa <= lvl_mem[lvl_ra];
        lvl_qb <= lvl_mem[NW'(qb_reg)];
    end

    logic [AW-1:0] anc_ra;

    always_comb
    begin
        priority if (cmd.op == tppcq_pkg::OP_FA)
            anc_ra = {km1, clr_reg};
        else if (cmd.op == tppcq_pkg::OP_FB)
            anc_ra = {km1, anc_qa};
        else if (cmd.op == tppcq_pkg::OP_PAR)
            anc_ra = {KW'(0), u_reg};
        else
            anc_ra = {k_reg, u_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tppcq_pkg::OP_CLR)
            anc_mem[{KW'(0), clr_reg}] <= '0;
        else if ((cmd.op == tppcq_pkg::OP_EVIS) && do_visit)
            anc_mem[{KW'(0), tgt_reg}] <= u_reg;
        else if (cmd.op == tppcq_pkg::OP_FC)
            anc_mem[{k_reg, clr_reg}] <= anc_qa;
        anc_qa <= anc_mem[anc_ra];
        anc_qb <= anc_mem[{k_reg, v_reg}];
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.op == tppcq_pkg::OP_CLR) && (clr_reg < MAX_NODES))
            pow_mem[clr_reg[IW-1:0]] <= pw_reg;
        pow_q <= pow_mem[pow_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg    <= '0;
            built_reg <= 1'b0;
        end
        else if (cmd.op == tppcq_pkg::OP_EDGE)
        begin
            if (built_reg)
            begin
                ec_reg    <= IW'(1);
                built_reg <= 1'b0;
            end
            else if (ec_reg < (MAX_NODES - 1))
                ec_reg <= ec_reg + IW'(1);
        end
        else if (cmd.op == tppcq_pkg::OP_BUILT)
            built_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tppcq_pkg::OP_QUERY:
            begin
                qa_reg  <= in_a;
                qb_reg  <= in_b;
                clr_reg <= '0;
                pw_reg  <= AWD'(1);
            end
            tppcq_pkg::OP_CLR:
            begin
                clr_reg <= clr_reg + NW'(1);
                pw_reg  <= pw_next;
            end
            tppcq_pkg::OP_ROOT:
            begin
                sp_reg  <= NW'(1);
                clr_reg <= '0;
                k_reg   <= KW'(1);
            end
            tppcq_pkg::OP_POP:
                sp_reg <= sp_reg - NW'(1);
            tppcq_pkg::OP_POPW:
                u_reg <= stk_q;
            tppcq_pkg::OP_ULVL:
            begin
                lvl_u_reg <= lvl_qa;
                ei_reg    <= '0;
            end
            tppcq_pkg::OP_EREAD:
                ei_reg <= ei_reg + IW'(1);
            tppcq_pkg::OP_ECHK:
            begin
                tgt_reg <= echk_tgt;
                hit_reg <= echk_hit;
            end
            tppcq_pkg::OP_EVIS:
            begin
                if (do_visit && push_ok)
                    sp_reg <= sp_reg + NW'(1);
            end
            tppcq_pkg::OP_FC:
            begin
                if (clr_reg == n_node)
                begin
                    clr_reg <= '0;
                    k_reg   <= k_reg + KW'(1);
                end
                else
                    clr_reg <= clr_reg + NW'(1);
            end
            tppcq_pkg::OP_QCHK:
            begin
                bad_reg <= q_bad;
                ans_reg <= '0;
                d_reg   <= '0;
            end
            tppcq_pkg::OP_QLVL:
            begin
                k_reg <= '0;
                if (lvl_qa < lvl_qb)
                begin
                    u_reg    <= NW'(qb_reg);
                    v_reg    <= NW'(qa_reg);
                    du_reg   <= lvl_qb;
                    dv_reg   <= lvl_qa;
                    diff_reg <= lvl_qb - lvl_qa;
                end
                else
                begin
                    u_reg    <= NW'(qa_reg);
                    v_reg    <= NW'(qb_reg);
                    du_reg   <= lvl_qa;
                    dv_reg   <= lvl_qb;
                    diff_reg <= lvl_qa - lvl_qb;
                end
            end
            tppcq_pkg::OP_LIFTW:
            begin
                if (diff_sh[0])
                    u_reg <= anc_qa;
                k_reg <= k_reg + KW'(1);
            end
            tppcq_pkg::OP_CMP:
                k_reg <= KW'(LIFT_LEVELS - 1);
            tppcq_pkg::OP_CLBW:
            begin
                if (anc_qa != anc_qb)
                begin
                    u_reg <= anc_qa;
                    v_reg <= anc_qb;
                end
                k_reg <= km1;
            end
            tppcq_pkg::OP_PARW:
                v_reg <= anc_qa;
            tppcq_pkg::OP_DIST:
                d_reg <= path_d;
            tppcq_pkg::OP_POWW:
                ans_reg <= ((d_reg == '0) || (d_reg > MAX_NODES)) ? '0 : pow_q;
            tppcq_pkg::OP_OUT:
            begin
                ans_out_reg <= ans_reg;
                len_out_reg <= tppcq_pkg::LEN_W'(d_reg);
                bad_out_reg <= bad_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat             = '0;
        stat.built       = built_reg;
        stat.bad         = q_bad;
        stat.clr_last    = (clr_reg == n_node);
        stat.stack_empty = (sp_reg == '0);
        stat.scan_done   = (ei_reg == ec_reg);
        stat.fill_last   = (clr_reg == n_node) && (k_reg == KW'(LIFT_LEVELS - 1));
        stat.lift_last   = (k_reg == KW'(LIFT_LEVELS - 1));
        stat.climb_last  = (k_reg == '0);
        stat.nodes_eq    = (u_reg == v_reg);
    end

    assign answer      = ans_out_reg;
    assign path_length = len_out_reg;
    assign bad_node    = bad_out_reg;

endmodule
